[rtl/mhe_pkg.sv]
// ----------------------------------------------------------------------------
// mhe_pkg
// Shared types and constants for the max-heap engine: command codes, entry
// layout, controller states and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package mhe_pkg;

    localparam int unsigned HEAP_DEPTH_DEF = 1024;
    localparam int unsigned KEY_W          = 8;
    localparam int unsigned PAYLOAD_W      = 56;
    localparam int unsigned COUNT_W        = 11;
    localparam int unsigned CMD_W          = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 3'd0,
        CMD_BUILD   = 3'd1,
        CMD_REWRITE = 3'd2,
        CMD_REMOVE  = 3'd3,
        CMD_CLEAR   = 3'd4
    } t_cmd;

    // key sits above the payload, as in the 64-bit store word
    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLD_RD,
        ST_SIFT_LD,
        ST_REM_RD,
        ST_REM_LD,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_DONE
    } t_state;

    // controller -> datapath strobes
    typedef struct packed {
        logic take;        // new beat accepted: clear flags
        logic set_err;     // flag error for this beat
        logic append;      // write entry at the store tail
        logic clear;       // drop all entries
        logic bld_init;    // take whole store into heap, set node counter
        logic rwr_init;    // load sifting entry with new root key
        logic rem_init;    // shrink heap by one
        logic bld_rd;      // read entry at node counter
        logic sift_ld;     // capture sifting entry, read its children
        logic rem_rd;      // read last live entry
        logic rem_ld;      // capture last entry, park old root behind heap
        logic sift_rd;     // read children of current node
        logic sift_cmp;    // compare and move one level
        logic kept_latch;  // record whether the root stayed put
        logic node_dec;    // step build to the previous node
        logic out_load;    // load the result register
    } t_ctl;

    // datapath -> controller status
    typedef struct packed {
        logic live_zero;
        logic store_full;
        logic bld_none;
        logic node_zero;
        logic stay;
        logic out_busy;
    } t_sts;

endpackage

[rtl/mhe_ctrl.sv]
// ----------------------------------------------------------------------------
// mhe_ctrl
// Controller state machine: decodes the command beat and sequences the
// loads, sift-down levels and the build walk over the datapath.
// ----------------------------------------------------------------------------
module mhe_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [mhe_pkg::CMD_W-1:0]   i_cmd,
    input  mhe_pkg::t_sts               i_sts,
    output logic                        o_in_ready,
    output mhe_pkg::t_ctl               o_ctl
);

    mhe_pkg::t_state r_state, n_state;
    logic            r_bld, n_bld;
    logic            r_rwr, n_rwr;
    logic            accept;

    assign o_in_ready = (r_state == mhe_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhe_pkg::ST_IDLE;
            r_bld   <= 1'b0;
            r_rwr   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bld   <= n_bld;
            r_rwr   <= n_rwr;
        end
    end

    // remember which operation owns the sift loop
    always_comb begin
        n_bld = r_bld;
        n_rwr = r_rwr;
        if (accept) begin
            n_bld = (i_cmd == mhe_pkg::CMD_BUILD);
            n_rwr = (i_cmd == mhe_pkg::CMD_REWRITE);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mhe_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        mhe_pkg::CMD_BUILD:
                            n_state = i_sts.bld_none ? mhe_pkg::ST_DONE : mhe_pkg::ST_BLD_RD;
                        mhe_pkg::CMD_REWRITE:
                            n_state = i_sts.live_zero ? mhe_pkg::ST_DONE : mhe_pkg::ST_SIFT_RD;
                        mhe_pkg::CMD_REMOVE:
                            n_state = i_sts.live_zero ? mhe_pkg::ST_DONE : mhe_pkg::ST_REM_RD;
                        default:
                            n_state = mhe_pkg::ST_DONE;
                    endcase
                end
            end
            mhe_pkg::ST_BLD_RD:  n_state = mhe_pkg::ST_SIFT_LD;
            mhe_pkg::ST_SIFT_LD: n_state = mhe_pkg::ST_SIFT_CMP;
            mhe_pkg::ST_REM_RD:  n_state = mhe_pkg::ST_REM_LD;
            mhe_pkg::ST_REM_LD:  n_state = mhe_pkg::ST_SIFT_RD;
            mhe_pkg::ST_SIFT_RD: n_state = mhe_pkg::ST_SIFT_CMP;
            mhe_pkg::ST_SIFT_CMP: begin
                if (!i_sts.stay) begin
                    n_state = mhe_pkg::ST_SIFT_RD;
                end else if (r_bld && !i_sts.node_zero) begin
                    n_state = mhe_pkg::ST_BLD_RD;
                end else begin
                    n_state = mhe_pkg::ST_DONE;
                end
            end
            mhe_pkg::ST_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = mhe_pkg::ST_IDLE;
                end
            end
            default: n_state = mhe_pkg::ST_IDLE;
        endcase
    end

    // datapath strobes
    always_comb begin
        o_ctl = '0;
        unique case (r_state)
            mhe_pkg::ST_IDLE: begin
                if (accept) begin
                    o_ctl.take = 1'b1;
                    unique case (i_cmd)
                        mhe_pkg::CMD_APPEND: begin
                            o_ctl.set_err = i_sts.store_full;
                            o_ctl.append  = !i_sts.store_full;
                        end
                        mhe_pkg::CMD_BUILD:   o_ctl.bld_init = 1'b1;
                        mhe_pkg::CMD_REWRITE: o_ctl.rwr_init = !i_sts.live_zero;
                        mhe_pkg::CMD_REMOVE: begin
                            o_ctl.set_err  = i_sts.live_zero;
                            o_ctl.rem_init = !i_sts.live_zero;
                        end
                        mhe_pkg::CMD_CLEAR:   o_ctl.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            mhe_pkg::ST_BLD_RD:  o_ctl.bld_rd  = 1'b1;
            mhe_pkg::ST_SIFT_LD: o_ctl.sift_ld = 1'b1;
            mhe_pkg::ST_REM_RD:  o_ctl.rem_rd  = 1'b1;
            mhe_pkg::ST_REM_LD:  o_ctl.rem_ld  = 1'b1;
            mhe_pkg::ST_SIFT_RD: o_ctl.sift_rd = 1'b1;
            mhe_pkg::ST_SIFT_CMP: begin
                o_ctl.sift_cmp   = 1'b1;
                o_ctl.kept_latch = i_sts.stay && r_rwr;
                o_ctl.node_dec   = i_sts.stay && r_bld && !i_sts.node_zero;
            end
            mhe_pkg::ST_DONE: o_ctl.out_load = !i_sts.out_busy;
            default: ;
        endcase
    end

endmodule

[rtl/mhe_dpath.sv]
// ----------------------------------------------------------------------------
// mhe_dpath
// Datapath: entry store with two registered read ports, counts, sift
// registers, root shadow register and the result register.
// ----------------------------------------------------------------------------
module mhe_dpath #(
    parameter int unsigned HEAP_DEPTH = mhe_pkg::HEAP_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mhe_pkg::t_ctl                   i_ctl,
    output mhe_pkg::t_sts                   o_sts,
    input  logic [mhe_pkg::KEY_W-1:0]       i_key,
    input  logic [mhe_pkg::PAYLOAD_W-1:0]   i_payload,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [mhe_pkg::KEY_W-1:0]       o_root_key,
    output logic [mhe_pkg::PAYLOAD_W-1:0]   o_root_payload,
    output logic [mhe_pkg::COUNT_W-1:0]     o_live_count,
    output logic [mhe_pkg::COUNT_W-1:0]     o_removed_count,
    output logic                            o_root_kept,
    output logic                            o_error
);

    localparam int unsigned AW = $clog2(HEAP_DEPTH);
    localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
    localparam int unsigned IW = AW + 2;
    localparam int unsigned XW = CW + mhe_pkg::COUNT_W;

    mhe_pkg::t_entry r_mem [HEAP_DEPTH];
    mhe_pkg::t_entry r_rd_a, r_rd_b;
    mhe_pkg::t_entry r_root;
    mhe_pkg::t_entry r_x;

    logic [CW-1:0] r_live, r_stored;
    logic [AW-1:0] r_node, r_cur, r_start;
    logic          r_kept, r_err;

    logic                            r_out_valid;
    logic [mhe_pkg::KEY_W-1:0]       r_out_key;
    logic [mhe_pkg::PAYLOAD_W-1:0]   r_out_payload;
    logic [mhe_pkg::COUNT_W-1:0]     r_out_live, r_out_removed;
    logic                            r_out_kept, r_out_err;

    logic [IW-1:0]         l_idx, right_idx, live_ext;
    logic                  l_ok, right_ok, take_l, take_r, stay;
    logic [mhe_pkg::KEY_W-1:0] best_key;
    logic [AW-1:0]         child_idx;
    mhe_pkg::t_entry       child_ent;
    logic [AW-1:0]         addr_a, addr_b, wr_addr;
    logic                  wr_en;
    mhe_pkg::t_entry       wr_data;
    logic [CW-1:0]         removed;
    logic [XW-1:0]         live_wide, removed_wide;

    // children of the current node and the one-level compare
    assign l_idx     = (IW'(r_cur) << 1) + IW'(1);
    assign right_idx = l_idx + IW'(1);
    assign live_ext  = IW'(r_live);
    assign l_ok      = l_idx < live_ext;
    assign right_ok  = right_idx < live_ext;
    assign take_l    = l_ok && (r_x.key < r_rd_a.key);
    assign best_key  = take_l ? r_rd_a.key : r_x.key;
    assign take_r    = right_ok && (best_key < r_rd_b.key);
    assign stay      = !take_l && !take_r;
    assign child_idx = take_r ? right_idx[AW-1:0] : l_idx[AW-1:0];
    assign child_ent = take_r ? r_rd_b : r_rd_a;

    always_comb begin
        if (i_ctl.bld_rd) begin
            addr_a = r_node;
        end else if (i_ctl.rem_rd) begin
            addr_a = r_live[AW-1:0];
        end else begin
            addr_a = l_idx[AW-1:0];
        end
    end
    assign addr_b = right_idx[AW-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cur;
        wr_data = r_x;
        priority if (i_ctl.append) begin
            wr_en   = 1'b1;
            wr_addr = r_stored[AW-1:0];
            wr_data = {i_key, i_payload};
        end else if (i_ctl.rem_ld) begin
            wr_en   = 1'b1;
            wr_addr = r_live[AW-1:0];
            wr_data = r_root;
        end else if (i_ctl.sift_cmp) begin
            wr_en   = 1'b1;
            wr_addr = r_cur;
            wr_data = stay ? r_x : child_ent;
        end else begin
            wr_en   = 1'b0;
        end
    end

    // store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    // shadow of store entry 0
    always_ff @(posedge i_clk) begin
        if (wr_en && (wr_addr == '0)) begin
            r_root <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rwr_init) begin
            r_x <= {i_key, r_root.payload};
        end else if (i_ctl.sift_ld || i_ctl.rem_ld) begin
            r_x <= r_rd_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live   <= '0;
            r_stored <= '0;
            r_node   <= '0;
            r_cur    <= '0;
            r_start  <= '0;
            r_kept   <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_live   <= '0;
                r_stored <= '0;
            end else if (i_ctl.append) begin
                r_stored <= r_stored + CW'(1);
            end else if (i_ctl.bld_init) begin
                r_live <= r_stored;
                r_node <= AW'((r_stored >> 1) - CW'(1));
            end else if (i_ctl.rem_init) begin
                r_live <= r_live - CW'(1);
            end
            if (i_ctl.node_dec) begin
                r_node <= r_node - AW'(1);
            end
            if (i_ctl.bld_rd) begin
                r_cur   <= r_node;
                r_start <= r_node;
            end else if (i_ctl.rwr_init || i_ctl.rem_ld) begin
                r_cur   <= '0;
                r_start <= '0;
            end else if (i_ctl.sift_cmp && !stay) begin
                r_cur <= child_idx;
            end
            if (i_ctl.take) begin
                r_err  <= i_ctl.set_err;
                r_kept <= 1'b0;
            end else if (i_ctl.kept_latch) begin
                r_kept <= (r_cur == r_start);
            end
        end
    end

    // result register
    assign removed      = r_stored - r_live;
    assign live_wide    = XW'(r_live);
    assign removed_wide = XW'(removed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_key     <= (r_live == '0) ? '0 : r_root.key;
            r_out_payload <= (r_live == '0) ? '0 : r_root.payload;
            r_out_live    <= live_wide[mhe_pkg::COUNT_W-1:0];
            r_out_removed <= removed_wide[mhe_pkg::COUNT_W-1:0];
            r_out_kept    <= r_kept;
            r_out_err     <= r_err;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_root_key      = r_out_key;
    assign o_root_payload  = r_out_payload;
    assign o_live_count    = r_out_live;
    assign o_removed_count = r_out_removed;
    assign o_root_kept     = r_out_kept;
    assign o_error         = r_out_err;

    assign o_sts.live_zero  = (r_live == '0);
    assign o_sts.store_full = (r_stored == CW'(HEAP_DEPTH));
    assign o_sts.bld_none   = (r_stored < CW'(2));
    assign o_sts.node_zero  = (r_node == '0);
    assign o_sts.stay       = stay;
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

`ifndef ASSERT_OFF
    a_live_le_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_stored)
        else $error("live count exceeds stored count");

    a_stored_le_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= CW'(HEAP_DEPTH))
        else $error("stored count exceeds store depth");

    a_sift_descends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.sift_cmp && !stay) |=> (r_cur > $past(r_cur)))
        else $error("sift-down step did not move to a deeper node");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.rem_init |=> (r_live == $past(r_live) - CW'(1)))
        else $error("remove did not shrink the heap by one");
`endif

endmodule

[rtl/max_heap_engine_top.sv]
// ----------------------------------------------------------------------------
// max_heap_engine_top
// Binary max-heap over an on-chip entry store with Floyd bottom-up build.
// ----------------------------------------------------------------------------
// Each input beat carries one command in tuser (append, build, rewrite root
// key, remove root, clear) and a key/payload pair in tdata; each command
// returns exactly one result beat with the root entry, live and removed
// counts and the root_kept/error flags. Entries are appended to the store
// and stay outside the heap until a build takes the whole store in. One
// command is worked at a time. Append, clear, unused codes and failing
// commands go straight to the result register. Rewrite and remove walk
// the heap a level at a time (read both children from the two store
// read ports, then compare and write back). Build sifts every inner node
// in turn: it loads each node, then descends level by level. The store
// itself needs no clearing pass: only entries below the stored count are
// ever used. A new command is taken while a finished result still waits
// on the output.
// ----------------------------------------------------------------------------
module max_heap_engine_top #(
    parameter int unsigned HEAP_DEPTH = mhe_pkg::HEAP_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: command beats
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [7:0] key, [63:8] payload
    input  logic [2:0]  i_s_tuser,   // [2:0] command
    // master side: result beats
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata    // [7:0] root_key, [63:8] root_payload,
                                     // [74:64] live_count, [85:75] removed_count,
                                     // [86] root_kept, [87] error
);

    mhe_pkg::t_ctl ctl;
    mhe_pkg::t_sts sts;

    logic [mhe_pkg::KEY_W-1:0]     root_key;
    logic [mhe_pkg::PAYLOAD_W-1:0] root_payload;
    logic [mhe_pkg::COUNT_W-1:0]   live_count, removed_count;
    logic                          root_kept, error;

    // sequence commands: decode, sift loop, build walk, result hand-off
    mhe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_cmd      (i_s_tuser),
        .i_sts      (sts),
        .o_in_ready (o_s_tready),
        .o_ctl      (ctl)
    );

    // hold the store, counts, sifting entry and the result register
    mhe_dpath #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_key           (i_s_tdata[7:0]),
        .i_payload       (i_s_tdata[63:8]),
        .i_out_ready     (i_m_tready),
        .o_out_valid     (o_m_tvalid),
        .o_root_key      (root_key),
        .o_root_payload  (root_payload),
        .o_live_count    (live_count),
        .o_removed_count (removed_count),
        .o_root_kept     (root_kept),
        .o_error         (error)
    );

    // pack the result fields, highest field first
    assign o_m_tdata = {error, root_kept, removed_count, live_count,
                        root_payload, root_key};

endmodule

[test/tb_max_heap_engine_top.sv]
// ----------------------------------------------------------------------------
// tb_max_heap_engine_top
// Self-checking bench for the max-heap engine.
// ----------------------------------------------------------------------------
// A command backlog is filled up front: first a short directed sequence,
// then random episodes. Each episode appends entries, builds the heap,
// mixes removes, rewrites, appends, rebuilds and spare codes; small ones
// drain. One episode overfills the store. A shadow heap steps on every
// accepted command beat and queues the root report it expects. Each result
// beat is checked field by field against the oldest queued report. Both
// sides idle at random, and the receiver holds off once for a long stretch
// so that the engine backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_max_heap_engine_top;

    import mhe_pkg::*;

    localparam int unsigned HEAP_DEPTH       = HEAP_DEPTH_DEF;
    localparam int unsigned RANDOM_ITEMS     = 1300;
    localparam int unsigned SMALL_FILL_MAX   = 64;
    localparam int unsigned LONG_HOLD_AT     = 150;
    localparam int unsigned LONG_HOLD_CYCLES = 600;
    localparam int unsigned DRAIN_CYCLES     = 64;
    localparam int unsigned LIMIT_CYCLES     = 2000000;
    // codes above CMD_CLEAR are spare: the engine reports its state only
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_W'(CMD_CLEAR + 1);
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;

    typedef struct {
        logic [CMD_W-1:0]     code;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } t_cmd_beat;

    typedef struct {
        logic [KEY_W-1:0]     root_key;
        logic [PAYLOAD_W-1:0] root_payload;
        logic [COUNT_W-1:0]   live_count;
        logic [COUNT_W-1:0]   removed_count;
        logic                 root_kept;
        logic                 error;
    } t_root_report;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata  = '0;   // [7:0] key, [63:8] payload
    logic [2:0]  i_s_tuser  = '0;   // [2:0] command
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [87:0] o_m_tdata;         // [7:0] root_key, [63:8] root_payload,
                                    // [74:64] live_count, [85:75] removed_count,
                                    // [86] root_kept, [87] error

    max_heap_engine_top #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_cmd_beat    cmd_backlog[$];
    t_root_report root_reports_due[$];

    // shadow heap: store, live part and stored count
    t_entry      heap_store [HEAP_DEPTH];
    int unsigned heap_live   = 0;
    int unsigned heap_stored = 0;

    // shadow counts used only to shape the generated sequences
    int unsigned gen_live   = 0;
    int unsigned gen_stored = 0;

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned cycle_count    = 0;

    // handshakes seen at the last rising edge, read by the falling-edge drivers
    logic s_beat = 1'b0;
    logic m_beat = 1'b0;

    // ------------------------------------------------------------------------
    // Shadow heap
    // ------------------------------------------------------------------------
    function automatic void exchange_slots(int unsigned a, int unsigned b);
        t_entry held;
        held          = heap_store[a];
        heap_store[a] = heap_store[b];
        heap_store[b] = held;
    endfunction

    // Sink the entry at start; ties keep the parent or favor the left child.
    // Returns 1 when the entry stayed at start.
    function automatic bit sift_entry_down(int unsigned start);
        int unsigned node;
        int unsigned larger;
        int unsigned child;
        bit          moving;
        node   = start;
        moving = 1'b1;
        while (moving) begin
            larger = node;
            child  = 2 * node + 1;
            if (child < heap_live && heap_store[larger].key < heap_store[child].key)
                larger = child;
            child = 2 * node + 2;
            if (child < heap_live && heap_store[larger].key < heap_store[child].key)
                larger = child;
            if (larger == node) begin
                moving = 1'b0;
            end else begin
                exchange_slots(larger, node);
                node = larger;
            end
        end
        return node == start;
    endfunction

    function automatic t_root_report apply_heap_cmd(logic [CMD_W-1:0] code,
                                                    logic [KEY_W-1:0] key,
                                                    logic [PAYLOAD_W-1:0] payload);
        t_root_report rpt;
        rpt.root_kept = 1'b0;
        rpt.error     = 1'b0;
        case (code)
            CMD_APPEND: begin
                if (heap_stored >= HEAP_DEPTH) begin
                    rpt.error = 1'b1;
                end else begin
                    heap_store[heap_stored].key     = key;
                    heap_store[heap_stored].payload = payload;
                    heap_stored++;
                end
            end
            CMD_BUILD: begin
                heap_live = heap_stored;
                for (int unsigned n = heap_live / 2; n > 0; n--)
                    void'(sift_entry_down(n - 1));
            end
            CMD_REWRITE: begin
                if (heap_live > 0) begin
                    heap_store[0].key = key;
                    rpt.root_kept     = sift_entry_down(0);
                end
            end
            CMD_REMOVE: begin
                if (heap_live == 0) begin
                    rpt.error = 1'b1;
                end else begin
                    heap_live--;
                    exchange_slots(0, heap_live);
                    void'(sift_entry_down(0));
                end
            end
            CMD_CLEAR: begin
                heap_live   = 0;
                heap_stored = 0;
            end
            default: ;
        endcase
        rpt.root_key      = (heap_live > 0) ? heap_store[0].key : '0;
        rpt.root_payload  = (heap_live > 0) ? heap_store[0].payload : '0;
        rpt.live_count    = heap_live[COUNT_W-1:0];
        rpt.removed_count = COUNT_W'(heap_stored - heap_live);
        return rpt;
    endfunction

    // ------------------------------------------------------------------------
    // Sequence generation
    // ------------------------------------------------------------------------
    // mostly tiny keys so ties come up often, plus the extremes
    function automatic logic [KEY_W-1:0] rand_key();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        if (pick < 5)
            return KEY_W'($urandom_range(0, 7));
        return KEY_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [PAYLOAD_W-1:0] rand_payload();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0:       bits = '0;
            1:       bits = '1;
            default: ;
        endcase
        return bits[PAYLOAD_W-1:0];
    endfunction

    task automatic queue_cmd(logic [CMD_W-1:0] code, logic [KEY_W-1:0] key,
                             logic [PAYLOAD_W-1:0] payload);
        t_cmd_beat beat;
        beat.code    = code;
        beat.key     = key;
        beat.payload = payload;
        cmd_backlog.push_back(beat);
        case (code)
            CMD_APPEND:  if (gen_stored < HEAP_DEPTH) gen_stored++;
            CMD_BUILD:   gen_live = gen_stored;
            CMD_REMOVE:  if (gen_live > 0) gen_live--;
            CMD_CLEAR: begin
                gen_live   = 0;
                gen_stored = 0;
            end
            default: ;
        endcase
    endtask

    task automatic queue_spare();
        queue_cmd(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), rand_key(),
                  rand_payload());
    endtask

    // Fill, build, churn, then drain small heaps to empty. Fills above the
    // store size run into the full-store error.
    task automatic queue_episode(int unsigned fill);
        int unsigned ops;
        int unsigned pick;
        if (gen_stored > HEAP_DEPTH / 2 || fill > HEAP_DEPTH / 2 || $urandom_range(0, 3) != 0)
            queue_cmd(CMD_CLEAR, rand_key(), rand_payload());
        repeat (fill) begin
            if ($urandom_range(0, 19) == 0)
                queue_spare();
            queue_cmd(CMD_APPEND, rand_key(), rand_payload());
        end
        queue_cmd(CMD_BUILD, rand_key(), rand_payload());
        ops = (fill > SMALL_FILL_MAX) ? 40 : $urandom_range(fill / 2, fill + 8);
        repeat (ops) begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
                queue_cmd(CMD_REMOVE, rand_key(), rand_payload());
            else if (pick < 14)
                queue_cmd(CMD_REWRITE, rand_key(), rand_payload());
            else if (pick < 16)
                queue_cmd(CMD_APPEND, rand_key(), rand_payload());
            else if (pick < 18)
                queue_cmd(CMD_BUILD, rand_key(), rand_payload());
            else
                queue_spare();
        end
        if (fill <= SMALL_FILL_MAX) begin
            while (gen_live > 0)
                queue_cmd(CMD_REMOVE, rand_key(), rand_payload());
            if ($urandom_range(0, 1) == 0)
                queue_cmd(CMD_REMOVE, rand_key(), rand_payload());
        end
    endtask

    task automatic queue_directed();
        // empty heap: remove fails, rewrite and build change nothing
        queue_cmd(CMD_REMOVE, 8'h00, '0);
        queue_cmd(CMD_REWRITE, 8'hFF, '1);
        queue_cmd(CMD_BUILD, 8'h00, '0);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            queue_cmd(CMD_W'(c), 8'hFF, '1);
        // extreme keys and payloads, then a run of tied keys
        queue_cmd(CMD_APPEND, 8'hFF, '1);
        queue_cmd(CMD_APPEND, 8'h00, '0);
        queue_cmd(CMD_APPEND, 8'h07, 56'hAA_AAAA_AAAA_AAAA);
        queue_cmd(CMD_APPEND, 8'h07, 56'h55_5555_5555_5555);
        queue_cmd(CMD_APPEND, 8'h07, rand_payload());
        queue_cmd(CMD_APPEND, 8'h07, rand_payload());
        queue_cmd(CMD_BUILD, 8'h00, '0);
        // rewrite to a tie with the children, then sink to the bottom, then top
        queue_cmd(CMD_REWRITE, 8'h07, '0);
        queue_cmd(CMD_REWRITE, 8'h00, '0);
        queue_cmd(CMD_REWRITE, 8'hFF, '0);
        queue_cmd(CMD_REMOVE, 8'h00, '0);
        queue_cmd(CMD_REMOVE, 8'h00, '0);
        // append lands behind the removed entries; rebuild takes them all back
        queue_cmd(CMD_APPEND, 8'hC8, rand_payload());
        queue_cmd(CMD_BUILD, 8'h00, '0);
        queue_cmd(CMD_CLEAR, 8'h00, '0);
        queue_cmd(CMD_REMOVE, 8'h00, '0);
        queue_cmd(CMD_REWRITE, 8'h01, '0);
    endtask

    // ------------------------------------------------------------------------
    // Rising edge: check result beats, step the shadow heap on command beats
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_root_report want;
        s_beat <= i_rst_n && i_s_tvalid && o_s_tready;
        m_beat <= i_rst_n && o_m_tvalid && i_m_tready;
        if (i_rst_n) begin
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES) begin
                $display("%0t: timeout, %0d reports still due", $time,
                         root_reports_due.size());
                $display("tb_max_heap_engine_top: errors");
                $finish;
            end else begin
                // results first: a beat always belongs to an earlier command
                if (o_m_tvalid && i_m_tready) begin
                    results_seen++;
                    if (root_reports_due.size() == 0) begin
                        $display("%0t: result beat %h with nothing expected", $time,
                                 o_m_tdata);
                        mismatch_count++;
                    end else begin
                        want = root_reports_due.pop_front();
                        check_field("root_key", want.root_key, o_m_tdata[7:0]);
                        check_field("root_payload", want.root_payload, o_m_tdata[63:8]);
                        check_field("live_count", want.live_count, o_m_tdata[74:64]);
                        check_field("removed_count", want.removed_count, o_m_tdata[85:75]);
                        check_field("root_kept", want.root_kept, o_m_tdata[86]);
                        check_field("error", want.error, o_m_tdata[87]);
                    end
                end
                if (i_s_tvalid && o_s_tready)
                    root_reports_due.push_back(apply_heap_cmd(i_s_tuser, i_s_tdata[7:0],
                                                              i_s_tdata[63:8]));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Falling edge: command driver. Hold a beat until taken, then idle for the
    // drawn gap. Burst mode gives stretches with no gaps at all.
    // ------------------------------------------------------------------------
    int unsigned send_wait  = 0;
    bit          send_burst = 1'b0;

    always @(negedge i_clk) begin
        t_cmd_beat beat;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !s_beat) begin
            // hold the offered beat
        end else if (send_wait > 0) begin
            send_wait--;
            i_s_tvalid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
            beat = cmd_backlog.pop_front();
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= {beat.payload, beat.key};
            i_s_tuser  <= beat.code;
            if ($urandom_range(0, 63) == 0)
                send_burst = !send_burst;
            send_wait = send_burst ? 0 : $urandom_range(0, 15);
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Falling edge: result receiver. Drop ready for a drawn stretch after each
    // taken beat; once, hold off long enough for the engine to stall its input.
    // ------------------------------------------------------------------------
    int unsigned recv_wait  = 0;
    bit          recv_burst = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (m_beat) begin
                if ($urandom_range(0, 63) == 0)
                    recv_burst = !recv_burst;
                recv_wait = recv_burst ? 0 : $urandom_range(0, 15);
                if (results_seen == LONG_HOLD_AT)
                    recv_wait = LONG_HOLD_CYCLES;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned target;
        int unsigned episode;
        int unsigned fill;
        queue_directed();
        // the one full-store fill counts toward the random item total
        target  = cmd_backlog.size() + RANDOM_ITEMS;
        episode = 0;
        while (cmd_backlog.size() < target) begin
            if (episode == 2)
                fill = HEAP_DEPTH + 2;
            else if ($urandom_range(0, 9) == 0)
                fill = $urandom_range(SMALL_FILL_MAX + 1, 200);
            else
                fill = $urandom_range(0, 40);
            queue_episode(fill);
            episode++;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait until every command is taken and every report has come back
        while (cmd_backlog.size() > 0 || i_s_tvalid || root_reports_due.size() > 0)
            @(posedge i_clk);
        // let any stray beat show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb_max_heap_engine_top: clean");
        else
            $display("tb_max_heap_engine_top: errors");
        $finish;
    end

endmodule

[files.f]
rtl/mhe_pkg.sv
rtl/mhe_ctrl.sv
rtl/mhe_dpath.sv
rtl/max_heap_engine_top.sv
test/tb_max_heap_engine_top.sv
